// ----- design/wgm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 6;
  localparam int CHAR_W  = 8;
  localparam int PLEN_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TEXT  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } wgm_op_t;

  localparam logic [CHAR_W-1:0] GLOB_ONE = 8'd63;  // '?'
  localparam logic [CHAR_W-1:0] GLOB_ANY = 8'd42;  // '*'

  // broadcast to every cell each cycle
  typedef struct packed {
    logic              text_step;
    logic              restart;
    logic [CHAR_W-1:0] char_code;
  } wgm_ctrl_t;

endpackage

`default_nettype wire

// ----- design/wgm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wgm_req_if;
  logic                          valid;
  logic                          ready;
  logic [wgm_pkg::OP_W-1:0]      opcode;
  logic [wgm_pkg::INDEX_W-1:0]   pattern_index;
  logic [wgm_pkg::CHAR_W-1:0]    char_code;

  modport source (output valid, output opcode, output pattern_index, output char_code,
                  input ready);
  modport sink   (input valid, input opcode, input pattern_index, input char_code,
                  output ready);
endinterface

interface wgm_rsp_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

interface wgm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wgm_pkg::PLEN_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/wgm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wgm_cell #(
  parameter int POS   = 0,
  parameter int LEN_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wgm_pkg::wgm_ctrl_t         ctrl,
  input  logic                       wr_en,
  input  logic [wgm_pkg::CHAR_W-1:0] wr_char,
  input  logic [LEN_W-1:0]           len_used,
  input  logic                       carry_in,
  input  logic                       adv_in,
  output logic                       carry_out,
  output logic                       adv_out,
  output logic                       hit
);
  import wgm_pkg::*;

  logic [CHAR_W-1:0] pchar;
  logic              act;
  logic              act_next;
  logic              in_use;
  logic              in_range;
  logic              at_len;
  logic              is_star;
  logic              cur;
  logic              char_ok;

  localparam logic [LEN_W-1:0] POS_L = LEN_W'(POS);

  assign in_use   = POS_L < len_used;
  assign at_len   = POS_L == len_used;
  assign in_range = in_use | at_len;
  assign is_star  = pchar == GLOB_ANY;
  assign char_ok  = (pchar == GLOB_ONE) | (pchar == ctrl.char_code);

  // closed active bit: own bit, or a star chain from the left
  assign cur       = (act & in_range) | carry_in;
  assign carry_out = cur & in_use & is_star;
  assign adv_out   = cur & in_use & ~is_star & char_ok;
  assign hit       = cur & at_len;
  assign act_next  = (cur & in_use & is_star) | adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= (POS == 0);
    end else if (ctrl.restart) begin
      act <= (POS == 0);
    end else if (ctrl.text_step) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pchar <= wr_char;
    end
  end

endmodule

`default_nettype wire

// ----- design/wgm_result.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wgm_result (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       matched_in,
  output logic       free,
  wgm_rsp_if.source  rsp
);

  logic valid;
  logic matched;

  assign free        = ~valid | rsp.ready;
  assign rsp.valid   = valid;
  assign rsp.matched = matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      matched <= matched_in;
    end
  end

endmodule

`default_nettype wire

// ----- design/wildcard_glob_matcher.sv -----
// Glob matcher: '?' matches one character, '*' any run, including none.
// req channel: opcode 0 writes char_code into pattern position pattern_index,
// opcode 1 feeds one text character, opcode 2 ends the text, opcode 3 is a no-op.
// rsp channel: one item per end-of-text item, matched = whole text matched.
// cfg channel: pattern_length (0..MAX_PATTERN, larger saturates); always ready,
// write it only while the block is idle.
// Throughput: one req item per cycle while req.ready is high. Every text
// character updates all pattern positions at once; the star closure ripples
// along the row of cells within the cycle, so that row length sets the clock path.
// matched is registered and is on rsp in the cycle after the end item is taken.
// A single output register holds the result; while it is full and rsp is
// stalled, req.ready drops until it drains.
// Reset: length 0, only position 0 active, output empty. Pattern characters
// are not cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic     clk,
  input  logic     rst,
  wgm_req_if.sink  req,
  wgm_rsp_if.source rsp,
  wgm_cfg_if.sink  cfg
);
  import wgm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [PLEN_W-1:0]      plen;
  logic [LEN_W-1:0]       len_used;
  logic                   accept;
  logic                   wr;
  logic                   stage_free;
  wgm_ctrl_t              ctrl;
  logic [MAX_PATTERN:0]   carry;
  logic [MAX_PATTERN:0]   adv;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] wr_en;
  logic                   act_last;
  logic                   cur_last;
  logic                   at_max;
  logic                   matched;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
    end else if (cfg.valid) begin
      plen <= cfg.data;
    end
  end

  always_comb begin
    if (int'(plen) > MAX_PATTERN) begin
      len_used = LEN_W'(MAX_PATTERN);
    end else begin
      len_used = LEN_W'(plen);
    end
  end

  assign req.ready      = stage_free;
  assign accept         = req.valid & req.ready;
  assign wr             = accept & (req.opcode == OP_WRITE);
  assign ctrl.text_step = accept & (req.opcode == OP_TEXT);
  assign ctrl.restart   = accept & (req.opcode == OP_END);
  assign ctrl.char_code = req.char_code;

  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
    assign wr_en[p] = wr & (int'(req.pattern_index) == p);

    wgm_cell #(
      .POS   (p),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .wr_en     (wr_en[p]),
      .wr_char   (req.char_code),
      .len_used  (len_used),
      .carry_in  (carry[p]),
      .adv_in    (adv[p]),
      .carry_out (carry[p+1]),
      .adv_out   (adv[p+1]),
      .hit       (hit[p])
    );
  end

  // final position: past the last pattern character
  assign at_max   = len_used == LEN_W'(MAX_PATTERN);
  assign cur_last = (act_last & at_max) | carry[MAX_PATTERN];
  assign matched  = (|hit) | (cur_last & at_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      act_last <= 1'b0;
    end else if (ctrl.restart) begin
      act_last <= 1'b0;
    end else if (ctrl.text_step) begin
      act_last <= adv[MAX_PATTERN];
    end
  end

  wgm_result u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (ctrl.restart),
    .matched_in (matched),
    .free       (stage_free),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import wgm_pkg::*;

  localparam int MAXP        = 64;
  localparam int ITEMS       = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [CHAR_W-1:0] CH_A = "a";
  localparam logic [CHAR_W-1:0] CH_B = "b";
  localparam logic [CHAR_W-1:0] CH_C = "c";
  localparam logic [CHAR_W-1:0] CH_X = "x";
  localparam logic [CHAR_W-1:0] CH_Y = "y";
  localparam logic [CHAR_W-1:0] CH_Z = "z";

  typedef struct {
    wgm_op_t            op;
    logic [INDEX_W-1:0] idx;
    logic [CHAR_W-1:0]  ch;
  } glob_item_t;

  logic clk;
  logic rst;

  wgm_req_if req_if();
  wgm_rsp_if rsp_if();
  wgm_cfg_if cfg_if();

  wildcard_glob_matcher #(.MAX_PATTERN(MAXP)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  glob_item_t  pending_items[$];
  glob_item_t  drv_item;
  logic        matched_due[$];
  logic        exp_matched;
  logic        req_taken;
  logic        cfg_taken;
  logic [31:0] cycle_cnt;
  int unsigned send_gap;
  int unsigned rsp_gap;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned accepted_cnt;
  int unsigned errors = 0;
  int unsigned pushed;

  // predictor state
  logic [CHAR_W-1:0] pat_mem [MAXP];
  logic [MAXP:0]     live_pos;
  logic [PLEN_W-1:0] glob_len;
  logic [MAXP:0]     closed;
  int unsigned       n_live;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // star closure of the live positions, up to length n
  function automatic logic [MAXP:0] star_closed(input int unsigned n);
    logic [MAXP:0] d;
    d = '0;
    for (int p = 0; p <= n; p++) begin
      if (live_pos[p]) d[p] = 1'b1;
      if (p < n && d[p] && pat_mem[p] == GLOB_ANY) d[p+1] = 1'b1;
    end
    return d;
  endfunction

  // mostly short gaps, a few long; no gaps at all while cycle_cnt[9:8] is zero
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[9:8] == 2'd0) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_pat_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_A;
    if (r < 45) return CH_B;
    if (r < 55) return CH_C;
    if (r < 75) return GLOB_ONE;
    if (r < 92) return GLOB_ANY;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // text bytes may be literal '?' or '*' too
  function automatic logic [CHAR_W-1:0] pick_text_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_A;
    if (r < 75) return CH_B;
    if (r < 85) return CH_C;
    if (r < 90) return GLOB_ONE;
    if (r < 93) return GLOB_ANY;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic push_item(input wgm_op_t op, input logic [INDEX_W-1:0] idx,
                           input logic [CHAR_W-1:0] ch);
    glob_item_t it;
    it.op  = op;
    it.idx = idx;
    it.ch  = ch;
    pending_items.push_back(it);
    if (op != OP_NONE) pushed++;
  endtask

  // sampled at the rising edge, where the driven side is stable
  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() != 0 || req_if.valid || matched_due.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input logic [PLEN_W-1:0] len);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= len;
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_text(input logic [CHAR_W-1:0] ch);
    push_item(OP_TEXT, INDEX_W'($urandom_range(0, MAXP-1)), ch);
  endtask

  task automatic push_end();
    push_item(OP_END, INDEX_W'($urandom_range(0, MAXP-1)),
              CHAR_W'($urandom_range(0, 255)));
  endtask

  // cycle limit
  always @(posedge clk) begin
    if (rst) begin
      cycle_cnt <= '0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid         <= 1'b0;
      req_if.opcode        <= OP_NONE;
      req_if.pattern_index <= '0;
      req_if.char_code     <= '0;
      send_gap             <= 0;
    end else if (!req_if.valid || req_taken) begin
      if (send_gap != 0) begin
        req_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        req_if.valid         <= 1'b1;
        req_if.opcode        <= drv_item.op;
        req_if.pattern_index <= drv_item.idx;
        req_if.char_code     <= drv_item.ch;
        send_gap             <= pick_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-offs while the sender still has plenty queued
  always @(negedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && accepted_cnt >= 500 + 700 * holds_done &&
                 pending_items.size() > 20) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rsp_gap      <= 0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_gap != 0) begin
      rsp_if.ready <= 1'b0;
      rsp_gap      <= rsp_gap - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_gap      <= pick_gap();
    end
  end

  // monitor, predictor and checker
  always @(posedge clk) begin
    if (rst) begin
      req_taken    <= 1'b0;
      cfg_taken    <= 1'b0;
      live_pos     = (MAXP+1)'(1);
      glob_len     = '0;
      accepted_cnt = 0;
      matched_due.delete();
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      cfg_taken <= cfg_if.valid && cfg_if.ready;
      if (cfg_if.valid && cfg_if.ready) glob_len = cfg_if.data;
      if (rsp_if.valid && rsp_if.ready) begin
        if (matched_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual matched %0b",
                   $time, rsp_if.matched);
          errors++;
        end else begin
          exp_matched = matched_due.pop_front();
          if (rsp_if.matched !== exp_matched) begin
            $display("%0t: matched mismatch, expected %0b, actual %0b",
                     $time, exp_matched, rsp_if.matched);
            errors++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        accepted_cnt++;
        n_live = (int'(glob_len) > MAXP) ? MAXP : int'(glob_len);
        case (req_if.opcode)
          OP_WRITE: begin
            pat_mem[req_if.pattern_index] = req_if.char_code;
          end
          OP_TEXT: begin
            closed   = star_closed(n_live);
            live_pos = '0;
            for (int p = 0; p < n_live; p++) begin
              if (closed[p]) begin
                if (pat_mem[p] == GLOB_ANY)
                  live_pos[p] = 1'b1;
                else if (pat_mem[p] == GLOB_ONE || pat_mem[p] == req_if.char_code)
                  live_pos[p+1] = 1'b1;
              end
            end
          end
          OP_END: begin
            closed = star_closed(n_live);
            matched_due.push_back(closed[n_live]);
            live_pos = (MAXP+1)'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // stimulus
  initial begin
    logic [CHAR_W-1:0] pat_copy [MAXP];
    logic [CHAR_W-1:0] text_q[$];
    int unsigned       r;
    int unsigned       plen_sel;
    int unsigned       n_use;
    int unsigned       j;

    rst          = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    pushed       = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // the store is undefined after reset: fill every entry before any text
    for (int k = 0; k < MAXP; k++) push_item(OP_WRITE, INDEX_W'(k), pick_pat_char());
    push_item(OP_WRITE, INDEX_W'(0), 8'h00);
    push_item(OP_WRITE, INDEX_W'(MAXP-1), 8'hFF);

    // empty pattern: only the empty text matches
    push_end();
    push_text(CH_A);
    push_end();
    push_item(OP_NONE, INDEX_W'(MAXP-1), 8'hFF);
    push_item(OP_END, INDEX_W'(MAXP-1), 8'hFF);

    set_length(PLEN_W'(4));
    push_item(OP_WRITE, INDEX_W'(0), CH_A);
    push_item(OP_WRITE, INDEX_W'(1), GLOB_ONE);
    push_item(OP_WRITE, INDEX_W'(2), GLOB_ANY);
    push_item(OP_WRITE, INDEX_W'(3), CH_B);
    push_text(CH_A); push_text(CH_X); push_text(CH_B); push_end();
    push_text(CH_A); push_text(CH_B); push_end();
    push_text(CH_A); push_text(CH_X); push_text(CH_Y); push_text(CH_Z);
    push_item(OP_WRITE, INDEX_W'(3), CH_Z);  // pattern changed mid-text
    push_end();

    // above the store size: saturates
    set_length(7'd127);
    push_text(CH_A);
    push_end();

    while (pushed < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75)      plen_sel = $urandom_range(0, 8);
      else if (r < 93) plen_sel = $urandom_range(9, 24);
      else if (r < 97) plen_sel = MAXP;
      else             plen_sel = $urandom_range(MAXP+1, 127);
      set_length(PLEN_W'(plen_sel));
      n_use = (plen_sel > MAXP) ? MAXP : plen_sel;
      for (int k = 0; k < n_use; k++) begin
        pat_copy[k] = pick_pat_char();
        push_item(OP_WRITE, INDEX_W'(k), pat_copy[k]);
      end

      repeat ($urandom_range(2, 8)) begin
        text_q.delete();
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // text built to fit the pattern, sometimes spoilt by one edit
          for (int k = 0; k < n_use; k++) begin
            if (pat_copy[k] == GLOB_ANY)
              repeat ($urandom_range(0, 3)) text_q.push_back(pick_text_char());
            else if (pat_copy[k] == GLOB_ONE)
              text_q.push_back(($urandom_range(0, 3) == 0) ?
                               CHAR_W'($urandom_range(0, 255)) : pick_text_char());
            else
              text_q.push_back(pat_copy[k]);
          end
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
              0: if (text_q.size() != 0)
                   text_q[$urandom_range(0, text_q.size()-1)] = pick_text_char();
              1: if (text_q.size() != 0)
                   text_q.delete($urandom_range(0, text_q.size()-1));
              default: text_q.push_back(pick_text_char());
            endcase
          end
        end else begin
          repeat ($urandom_range(0, 10)) text_q.push_back(pick_text_char());
        end

        foreach (text_q[i]) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            push_item(OP_NONE, INDEX_W'($urandom_range(0, MAXP-1)),
                      CHAR_W'($urandom_range(0, 255)));
          end else if (r < 7) begin
            j = $urandom_range(0, MAXP-1);
            pat_copy[j] = pick_pat_char();
            push_item(OP_WRITE, INDEX_W'(j), pat_copy[j]);
          end
          push_text(text_q[i]);
        end
        push_end();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- wildcard_glob_matcher.f -----
design/wgm_pkg.sv
design/wgm_if.sv
design/wgm_cell.sv
design/wgm_result.sv
design/wildcard_glob_matcher.sv
test/tb_top.sv
